/* src/agst_pkg.sv */
// agst_pkg: shared constants, tables and types for the scale and tilt pipeline
// no dependencies
package agst_pkg;

   localparam int ANGLE_ITERATIONS = 16;
   localparam int ATAN_TAB_LEN     = 24;
   localparam int CORDIC_STEPS     =
      (ANGLE_ITERATIONS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : ANGLE_ITERATIONS;

   // square root stage count and first stage indexes
   localparam int SQRT_STEPS   = 24;
   localparam int SQRT_FIRST   = 3;
   localparam int CORDIC_FIRST = SQRT_FIRST + SQRT_STEPS;
   localparam int FINAL_STAGE  = CORDIC_FIRST + CORDIC_STEPS;
   localparam int DEPTH        = FINAL_STAGE + 1;

   // accel scaling constants: (m*981 + 800) / 1600
   localparam logic [9:0]  ACC_MUL   = 10'd981;
   localparam logic [9:0]  ACC_BIAS  = 10'd800;
   localparam logic [23:0] ACC_RECIP = 24'd10737419;  // ceil(2^28 / 25)
   localparam int          ACC_SHIFT = 28;
   localparam logic [6:0]  GYR_MUL   = 7'd125;
   localparam logic [6:0]  GYR_BIAS  = 7'd64;
   localparam logic [14:0] ANGLE_MAX = 15'd23040;

   // atan(2^-i) in degrees * 65536
   localparam logic [21:0] ATAN_TAB [ATAN_TAB_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
      22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
      22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
   };

   // everything one sample set carries through the pipeline
   typedef struct packed {
      logic signed [2:0][15:0] acc_raw;
      logic signed [2:0][15:0] acc_out;
      logic signed [2:0][15:0] gyr_out;
      logic [2:0][24:0]        acc_tmp;
      logic [2:0][42:0]        acc_prod;
      logic [2:0][30:0]        sq;
      logic [1:0][47:0]        rad;
      logic [1:0][25:0]        rem;
      logic [1:0][23:0]        root;
      logic signed [1:0][27:0] cx;
      logic signed [1:0][27:0] cy;
      logic signed [1:0][24:0] cz;
      logic signed [1:0][15:0] angle;
   } stage_type;

endpackage

/* src/agst_if.sv */
// agst_req_if and agst_rsp_if: valid/ready channels for requests and results
// depends on nothing
interface agst_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x_raw;
   logic signed [15:0] accel_y_raw;
   logic signed [15:0] accel_z_raw;
   logic signed [15:0] gyro_x_raw;
   logic signed [15:0] gyro_y_raw;
   logic signed [15:0] gyro_z_raw;
   modport source (output valid, accel_x_raw, accel_y_raw, accel_z_raw,
                   gyro_x_raw, gyro_y_raw, gyro_z_raw, input ready);
   modport sink (input valid, accel_x_raw, accel_y_raw, accel_z_raw,
                 gyro_x_raw, gyro_y_raw, gyro_z_raw, output ready);
endinterface

interface agst_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x_mps2;
   logic signed [15:0] accel_y_mps2;
   logic signed [15:0] accel_z_mps2;
   logic signed [15:0] gyro_x_dps;
   logic signed [15:0] gyro_y_dps;
   logic signed [15:0] gyro_z_dps;
   logic signed [15:0] pitch_deg;
   logic signed [15:0] roll_deg;
   modport source (output valid, accel_x_mps2, accel_y_mps2, accel_z_mps2,
                   gyro_x_dps, gyro_y_dps, gyro_z_dps, pitch_deg, roll_deg,
                   input ready);
   modport sink (input valid, accel_x_mps2, accel_y_mps2, accel_z_mps2,
                 gyro_x_dps, gyro_y_dps, gyro_z_dps, pitch_deg, roll_deg,
                 output ready);
endinterface

/* src/accel_gyro_scale_tilt_top.sv */
// accel_gyro_scale_tilt_top: scaling of six sensor axes plus pitch and roll
// throughput: one request per cycle; each stage holds under back pressure
// the 24 square root stages and the per-iteration CORDIC stages set depth
// reset: synchronous, active high, clears all stage valid bits
// depends on agst_pkg and agst_if
module accel_gyro_scale_tilt_top
   import agst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   agst_req_if.sink   req_if,
   agst_rsp_if.source rsp_if
);

   stage_type       st_ff [DEPTH];
   stage_type       st_in [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH:0]   rdy;

   // per-stage ready chain
   assign rdy[DEPTH] = rsp_if.ready;
   assign req_if.ready = rdy[0];

   genvar k;
   generate
      for (k = 0; k < DEPTH; k++) begin : g_stage
         assign rdy[k] = !vld_ff[k] || rdy[k+1];

         // stage logic
         if (k == 0) begin : g_cap
            always_comb begin
               st_in[k] = '0;
               st_in[k].acc_raw[0] = req_if.accel_x_raw;
               st_in[k].acc_raw[1] = req_if.accel_y_raw;
               st_in[k].acc_raw[2] = req_if.accel_z_raw;
               st_in[k].gyr_out[0] = req_if.gyro_x_raw;
               st_in[k].gyr_out[1] = req_if.gyro_y_raw;
               st_in[k].gyr_out[2] = req_if.gyro_z_raw;
            end
         end else if (k == 1) begin : g_mul
            // squares, accel first product, gyro scaling
            always_comb begin
               logic [16:0] m;
               logic [23:0] g;
               st_in[k] = st_ff[k-1];
               for (int a = 0; a < 3; a++) begin
                  m = st_ff[k-1].acc_raw[a][15] ?
                      17'(-{st_ff[k-1].acc_raw[a][15], st_ff[k-1].acc_raw[a]}) :
                      {1'b0, st_ff[k-1].acc_raw[a]};
                  st_in[k].sq[a] = 31'(m * m);
                  st_in[k].acc_tmp[a] = 25'(m * ACC_MUL) + 25'(ACC_BIAS);
                  m = st_ff[k-1].gyr_out[a][15] ?
                      17'(-{st_ff[k-1].gyr_out[a][15], st_ff[k-1].gyr_out[a]}) :
                      {1'b0, st_ff[k-1].gyr_out[a]};
                  g = 24'(m * GYR_MUL) + 24'(GYR_BIAS);
                  st_in[k].gyr_out[a] = st_ff[k-1].gyr_out[a][15] ?
                      -$signed(g[22:7]) : $signed(g[22:7]);
               end
            end
         end else if (k == 2) begin : g_sum
            // radicands and accel reciprocal product
            always_comb begin
               st_in[k] = st_ff[k-1];
               st_in[k].rad[0] = {32'({1'b0, st_ff[k-1].sq[1]} + {1'b0, st_ff[k-1].sq[2]}),
                                  16'd0};
               st_in[k].rad[1] = {32'({1'b0, st_ff[k-1].sq[0]} + {1'b0, st_ff[k-1].sq[2]}),
                                  16'd0};
               for (int a = 0; a < 3; a++) begin
                  st_in[k].acc_prod[a] = 43'(st_ff[k-1].acc_tmp[a][24:6] * ACC_RECIP);
               end
            end
         end else if (k < CORDIC_FIRST) begin : g_sqrt
            // one result bit of the square root per stage; the first also finishes the accel outputs
            localparam int J = k - SQRT_FIRST;
            always_comb begin
               logic [27:0] t;
               logic [27:0] trial;
               st_in[k] = st_ff[k-1];
               if (k == SQRT_FIRST) begin
                  st_in[k].rem  = '0;
                  st_in[k].root = '0;
                  for (int a = 0; a < 3; a++) begin
                     st_in[k].acc_out[a] = st_ff[k-1].acc_raw[a][15] ?
                        -$signed({1'b0, st_ff[k-1].acc_prod[a][42:ACC_SHIFT]}) :
                        $signed({1'b0, st_ff[k-1].acc_prod[a][42:ACC_SHIFT]});
                  end
               end
               for (int c = 0; c < 2; c++) begin
                  t = {(k == SQRT_FIRST) ? 26'd0 : st_ff[k-1].rem[c],
                       st_ff[k-1].rad[c][47-2*J -: 2]};
                  trial = {2'b00, ((k == SQRT_FIRST) ? 24'd0 : st_ff[k-1].root[c]),
                           2'b01};
                  if (t >= trial) begin
                     st_in[k].rem[c]  = 26'(t - trial);
                     st_in[k].root[c] = {st_ff[k-1].root[c][22:0], 1'b1};
                  end else begin
                     st_in[k].rem[c]  = t[25:0];
                     st_in[k].root[c] = {st_ff[k-1].root[c][22:0], 1'b0};
                  end
                  if (k == SQRT_FIRST) begin
                     st_in[k].root[c] = {23'd0, t >= trial};
                  end
               end
            end
         end else if (k < FINAL_STAGE) begin : g_cordic
            // one vectoring rotation per stage
            localparam int I = k - CORDIC_FIRST;
            always_comb begin
               logic signed [27:0] x;
               logic signed [27:0] y;
               logic signed [24:0] z;
               st_in[k] = st_ff[k-1];
               for (int c = 0; c < 2; c++) begin
                  if (k == CORDIC_FIRST) begin
                     x = $signed({4'd0, st_ff[k-1].root[c]});
                     y = 28'($signed(st_ff[k-1].acc_raw[c])) <<< 8;
                     z = '0;
                  end else begin
                     x = st_ff[k-1].cx[c];
                     y = st_ff[k-1].cy[c];
                     z = st_ff[k-1].cz[c];
                  end
                  if (!y[27]) begin
                     st_in[k].cx[c] = x + (y >>> I);
                     st_in[k].cy[c] = y - (x >>> I);
                     st_in[k].cz[c] = z + $signed({3'd0, ATAN_TAB[I]});
                  end else begin
                     st_in[k].cx[c] = x - (y >>> I);
                     st_in[k].cy[c] = y + (x >>> I);
                     st_in[k].cz[c] = z - $signed({3'd0, ATAN_TAB[I]});
                  end
               end
            end
         end else begin : g_round
            // round angle, clamp, zero operand case
            always_comb begin
               logic [24:0] m;
               logic [16:0] r;
               logic [14:0] q;
               st_in[k] = st_ff[k-1];
               for (int c = 0; c < 2; c++) begin
                  m = st_ff[k-1].cz[c][24] ? 25'(-st_ff[k-1].cz[c]) :
                      25'(st_ff[k-1].cz[c]);
                  r = 17'((m + 25'd128) >> 8);
                  q = (r > {2'b00, ANGLE_MAX}) ? ANGLE_MAX : r[14:0];
                  st_in[k].angle[c] = st_ff[k-1].cz[c][24] ? -$signed({1'b0, q}) :
                                      $signed({1'b0, q});
                  if (st_ff[k-1].root[c] == '0 && st_ff[k-1].acc_raw[c] == '0) begin
                     st_in[k].angle[c] = '0;
                  end
               end
            end
         end

         // stage registers
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (rdy[k+1] || !vld_ff[k]) begin
               vld_ff[k] <= (k == 0) ? req_if.valid : vld_ff[(k == 0) ? 0 : k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               st_ff[k] <= st_in[k];
            end
         end
      end
   endgenerate

   // result channel
   assign rsp_if.valid        = vld_ff[DEPTH-1];
   assign rsp_if.accel_x_mps2 = st_ff[DEPTH-1].acc_out[0];
   assign rsp_if.accel_y_mps2 = st_ff[DEPTH-1].acc_out[1];
   assign rsp_if.accel_z_mps2 = st_ff[DEPTH-1].acc_out[2];
   assign rsp_if.gyro_x_dps   = st_ff[DEPTH-1].gyr_out[0];
   assign rsp_if.gyro_y_dps   = st_ff[DEPTH-1].gyr_out[1];
   assign rsp_if.gyro_z_dps   = st_ff[DEPTH-1].gyr_out[2];
   assign rsp_if.pitch_deg    = st_ff[DEPTH-1].angle[0];
   assign rsp_if.roll_deg     = st_ff[DEPTH-1].angle[1];

endmodule

/* src/agst_checker.sv */
// agst_checker: port-level checks on the scale and tilt top level
// depends on agst_pkg; bound to accel_gyro_scale_tilt_top
module agst_checker
   import agst_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] pitch_deg,
   input logic signed [15:0] roll_deg,
   input logic signed [15:0] gyro_x_dps
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pitch_deg) && $stable(roll_deg))
      else $error("stalled result changed");

   // angles stay within plus or minus ninety degrees
   a_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pitch_deg <= 16'sd23040 && pitch_deg >= -16'sd23040 &&
                    roll_deg <= 16'sd23040 && roll_deg >= -16'sd23040)
      else $error("angle out of range");

   // rate stays within scaled full scale
   a_gyro: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> gyro_x_dps <= 16'sd32000 && gyro_x_dps >= -16'sd32000)
      else $error("gyro rate out of range");

endmodule

bind accel_gyro_scale_tilt_top agst_checker u_agst_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .pitch_deg (rsp_if.pitch_deg),
   .roll_deg  (rsp_if.roll_deg),
   .gyro_x_dps(rsp_if.gyro_x_dps)
);

/* dv/tb_accel_gyro_scale_tilt_top.sv */
`timescale 1ns / 1ps
// tb_accel_gyro_scale_tilt_top: self-checking bench for the scale and tilt pipeline
// drives random and table-based sample sets, predicts or takes from the table every result, checks in order
// depends on agst_pkg, agst_if and accel_gyro_scale_tilt_top
module tb_accel_gyro_scale_tilt_top;
   import agst_pkg::*;

   localparam int RANDOM_SETS = 440;
   localparam int TAIL_SETS   = 80;
   localparam int DRAIN_WAIT  = 2 * DEPTH + 20;
   localparam int IDLE_LIMIT  = 4000;

   typedef struct packed {
      logic signed [15:0] ax, ay, az, gx, gy, gz;
   } sample_set_type;

   typedef struct packed {
      logic signed [15:0] ax, ay, az, gx, gy, gz, pitch, roll;
   } scaled_set_type;

   typedef struct {
      sample_set_type stim;
      bit             has_fixed;
      scaled_set_type fixed;
   } table_row_type;

   logic clock;
   logic reset;
   agst_req_if req_if ();
   agst_rsp_if rsp_if ();

   accel_gyro_scale_tilt_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   scaled_set_type expected_q[$];
   int             error_count;
   int             idle_cycles;
   bit             stall_enable;
   bit             stim_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // accel scaling: m*981/1600 rounded, ties away from zero
   function automatic logic signed [15:0] scale_accel(input logic signed [15:0] raw);
      longint m;
      m = (raw < 0) ? -longint'(raw) : longint'(raw);
      m = (m * 981 + 800) / 1600;
      return (raw < 0) ? 16'(-m) : 16'(m);
   endfunction

   // gyro scaling: m*125/128 rounded, ties away from zero
   function automatic logic signed [15:0] scale_gyro(input logic signed [15:0] raw);
      longint m;
      m = (raw < 0) ? -longint'(raw) : longint'(raw);
      m = (m * 125 + 64) >>> 7;
      return (raw < 0) ? 16'(-m) : 16'(m);
   endfunction

   // floor of the integer square root
   function automatic longint int_sqrt(input longint v);
      longint root, bitv;
      root = 0;
      bitv = longint'(1) << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // tilt angle of numerator n over the magnitude of p and q, in 1/256 degree
   function automatic logic signed [15:0] tilt_angle(input longint n, input longint p,
                                                     input longint q);
      longint x, y, z, dx, dy, m, a;
      x = int_sqrt((p * p + q * q) << 16);
      y = n * 256;
      z = 0;
      if (x == 0 && y == 0) return 16'sd0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
         end else begin
            x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
         end
      end
      m = (((z < 0) ? -z : z) + 128) >>> 8;
      a = (z < 0) ? -m : m;
      if (a > 23040) a = 23040;
      if (a < -23040) a = -23040;
      return 16'(a);
   endfunction

   function automatic scaled_set_type predict_scaled(input sample_set_type s);
      scaled_set_type r;
      r.ax    = scale_accel(s.ax);
      r.ay    = scale_accel(s.ay);
      r.az    = scale_accel(s.az);
      r.gx    = scale_gyro(s.gx);
      r.gy    = scale_gyro(s.gy);
      r.gz    = scale_gyro(s.gz);
      r.pitch = tilt_angle(s.ax, s.ay, s.az);
      r.roll  = tilt_angle(s.ay, s.ax, s.az);
      return r;
   endfunction

   function automatic sample_set_type random_set();
      sample_set_type s;
      int kind;
      kind = $urandom_range(0, 9);
      s = sample_set_type'({$urandom, $urandom, $urandom});
      // small values around zero and single-axis tilts stress the angle edges
      if (kind == 0) begin
         s.ax = 16'($urandom_range(0, 8)) - 16'sd4;
         s.ay = 16'($urandom_range(0, 8)) - 16'sd4;
         s.az = 16'($urandom_range(0, 8)) - 16'sd4;
      end else if (kind == 1) begin
         s.ay = 16'sd0;
         s.az = 16'sd0;
      end else if (kind == 2) begin
         s.ax = 16'sd0;
         s.az = 16'sd0;
      end else if (kind == 3) begin
         s.ax = s.ax >>> 4; s.ay = s.ay >>> 4; s.az = 16'sd16384 + (s.az >>> 6);
      end
      return s;
   endfunction

   // directed table; fixed rows carry values plain from the scaling and special cases
   function automatic table_row_type mk(input int ax, ay, az, gx, gy, gz,
                                        input bit fx = 0,
                                        input int eax = 0, eay = 0, eaz = 0, egx = 0,
                                        input int egy = 0, egz = 0, ep = 0, er = 0);
      table_row_type t;
      t.stim = '{16'(ax), 16'(ay), 16'(az), 16'(gx), 16'(gy), 16'(gz)};
      t.has_fixed = fx;
      t.fixed = '{16'(eax), 16'(eay), 16'(eaz), 16'(egx), 16'(egy), 16'(egz),
                  16'(ep), 16'(er)};
      return t;
   endfunction

   table_row_type directed_rows[$];

   initial begin
      directed_rows.push_back(mk(0, 0, 0, 0, 0, 0, 1));
      directed_rows.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767));
      directed_rows.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768));
      directed_rows.push_back(mk(0, 0, 16384, 1, -1, 64, 1, 0, 0, 10045, 1, -1, 63, 0, 0));
      directed_rows.push_back(mk(32767, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(-32768, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(0, 32767, 0, 0, 0, 0));
      directed_rows.push_back(mk(0, -32768, 0, 0, 0, 0));
      directed_rows.push_back(mk(1, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(-1, -1, 0, 0, 0, 0));
      directed_rows.push_back(mk(16384, 0, 16384, 0, 0, 0));
      directed_rows.push_back(mk(-16384, 16384, -16384, 0, 0, 0));
      directed_rows.push_back(mk(0, 0, -32768, 0, 0, 0));
      directed_rows.push_back(mk(800, -800, 1600, 64, -64, 192));
      directed_rows.push_back(mk(-32768, 32767, 1, 21845, -21846, 12345));
      directed_rows.push_back(mk(5000, -12000, -30000, -7, 7, -128));
   end

   // response checking at the rising edge
   always @(posedge clock) begin
      scaled_set_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.accel_x_mps2, rsp_if.accel_y_mps2, rsp_if.accel_z_mps2,
                 rsp_if.gyro_x_dps, rsp_if.gyro_y_dps, rsp_if.gyro_z_dps,
                 rsp_if.pitch_deg, rsp_if.roll_deg};
         if (expected_q.size() == 0) begin
            $error("result with no request outstanding");
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (got.ax !== want.ax) begin
               $error("accel_x_mps2 exp %0d got %0d", want.ax, got.ax); error_count++;
            end
            if (got.ay !== want.ay) begin
               $error("accel_y_mps2 exp %0d got %0d", want.ay, got.ay); error_count++;
            end
            if (got.az !== want.az) begin
               $error("accel_z_mps2 exp %0d got %0d", want.az, got.az); error_count++;
            end
            if (got.gx !== want.gx) begin
               $error("gyro_x_dps exp %0d got %0d", want.gx, got.gx); error_count++;
            end
            if (got.gy !== want.gy) begin
               $error("gyro_y_dps exp %0d got %0d", want.gy, got.gy); error_count++;
            end
            if (got.gz !== want.gz) begin
               $error("gyro_z_dps exp %0d got %0d", want.gz, got.gz); error_count++;
            end
            if (got.pitch !== want.pitch) begin
               $error("pitch_deg exp %0d got %0d", want.pitch, got.pitch); error_count++;
            end
            if (got.roll !== want.roll) begin
               $error("roll_deg exp %0d got %0d", want.roll, got.roll); error_count++;
            end
         end
      end
   end

   // result side back pressure in random bursts
   initial begin
      int burst;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (stall_enable && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_if.ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // watchdog on cycles with no request or result moving
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (stim_done && expected_q.size() == 0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("accel_gyro_scale_tilt_top regression: fail");
            $finish;
         end
      end
   end

   task automatic send_request(input sample_set_type s, input scaled_set_type want);
      req_if.valid       <= 1'b1;
      req_if.accel_x_raw <= s.ax;
      req_if.accel_y_raw <= s.ay;
      req_if.accel_z_raw <= s.az;
      req_if.gyro_x_raw  <= s.gx;
      req_if.gyro_y_raw  <= s.gy;
      req_if.gyro_z_raw  <= s.gz;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_q.push_back(want);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if (stall_enable && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   // stimulus
   initial begin
      sample_set_type s;
      error_count  = 0;
      stall_enable = 1'b1;
      stim_done    = 1'b0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      {req_if.accel_x_raw, req_if.accel_y_raw, req_if.accel_z_raw,
       req_if.gyro_x_raw, req_if.gyro_y_raw, req_if.gyro_z_raw} = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].stim, directed_rows[i].has_fixed ?
                      directed_rows[i].fixed : predict_scaled(directed_rows[i].stim));
         sender_gap();
      end

      // hold off until the pipeline is empty
      req_if.valid <= 1'b0;
      wait (expected_q.size() == 0);
      @(negedge clock);

      // random sets, then a final stretch with no idling
      for (int i = 0; i < RANDOM_SETS; i++) begin
         if (i == RANDOM_SETS - TAIL_SETS) stall_enable = 1'b0;
         s = random_set();
         send_request(s, predict_scaled(s));
         sender_gap();
      end
      req_if.valid <= 1'b0;
      stim_done = 1'b1;

      wait (expected_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("accel_gyro_scale_tilt_top regression: pass");
      end else begin
         $display("accel_gyro_scale_tilt_top regression: fail");
      end
      $finish;
   end

endmodule
